@@ design/attack_decay_envelope_assert.svh @@
// Assertion macros for the attack-decay envelope block.
`ifndef ATTACK_DECAY_ENVELOPE_ASSERT_SVH
`define ATTACK_DECAY_ENVELOPE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property while the block is out of reset.
`define ADE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check a property at every edge, reset included.
`define ADE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define ADE_ASSERT(lbl, prop, msg)
`define ADE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ design/ade_pkg.sv @@
// Types, widths and constants shared by the attack-decay envelope modules.
package ade_pkg;

    localparam int LEVEL_W = 23;
    localparam int COEFF_W = 24;
    localparam int DIFF_W  = 25;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int FRAC_W  = 24;
    localparam int QUOT_W  = PROD_W - FRAC_W;
    localparam int SUM_W   = 27;
    localparam int CFG_IDX_W = 2;
    localparam int PHASE_CODE_W = 2;

    localparam logic [LEVEL_W-1:0] ONE_Q22 = 23'd4194304;
    localparam logic signed [SUM_W-1:0] ONE_SUM = 27'sd4194304;

    localparam logic [COEFF_W-1:0] ATTACK_COEFF_RST  = 24'd16700586;
    localparam logic [COEFF_W-1:0] DECAY_COEFF_RST   = 24'd16769538;
    localparam logic [LEVEL_W-1:0] ATTACK_TARGET_RST = 23'd5033165;
    // -838861 as a 23 bit two's complement pattern
    localparam logic [LEVEL_W-1:0] DECAY_TARGET_RST  = 23'd7549747;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEFF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_COEFF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_TARGET = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_TARGET  = 2'd3;

    localparam logic [PHASE_CODE_W-1:0] PH_CODE_IDLE   = 2'd0;
    localparam logic [PHASE_CODE_W-1:0] PH_CODE_ATTACK = 2'd1;
    localparam logic [PHASE_CODE_W-1:0] PH_CODE_DECAY  = 2'd2;

    typedef enum logic [2:0] {
        PHASE_IDLE   = 3'b001,
        PHASE_ATTACK = 3'b010,
        PHASE_DECAY  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [COEFF_W-1:0]        attack_coeff;
        logic [COEFF_W-1:0]        decay_coeff;
        logic [LEVEL_W-1:0]        attack_target;
        logic signed [LEVEL_W-1:0] decay_target;
    } ade_cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic [LEVEL_W-1:0] level;
    } ade_state_t;

endpackage

@@ design/ade_step.sv @@
// One envelope sample: pole step toward the phase target, then clamp.
module ade_step
    import ade_pkg::*;
(
    input  ade_cfg_t   cfg,
    input  ade_state_t cur,
    input  logic       trigger,
    output ade_state_t nxt
);

    phase_t                    ph_eff;
    logic signed [DIFF_W-1:0]  target;
    logic [COEFF_W-1:0]        coeff;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]  prod;
    logic signed [QUOT_W-1:0]  quot;
    logic signed [SUM_W-1:0]   sum;

    // A trigger restarts attack from the current level.
    assign ph_eff = trigger ? PHASE_ATTACK : cur.phase;

    always_comb begin
        case (ph_eff)
            PHASE_ATTACK: begin
                target = signed'({2'b00, cfg.attack_target});
                coeff  = cfg.attack_coeff;
            end
            PHASE_DECAY: begin
                target = signed'({{(DIFF_W-LEVEL_W){cfg.decay_target[LEVEL_W-1]}},
                                  cfg.decay_target});
                coeff  = cfg.decay_coeff;
            end
            default: begin
                target = '0;
                coeff  = '0;
            end
        endcase
    end

    assign diff = signed'({2'b00, cur.level}) - target;
    assign prod = diff * signed'({1'b0, coeff});
    // Arithmetic shift: floor division by 2^24.
    assign quot = prod[PROD_W-1:FRAC_W];
    assign sum  = signed'({{(SUM_W-DIFF_W){target[DIFF_W-1]}}, target})
                + signed'({{(SUM_W-QUOT_W){quot[QUOT_W-1]}}, quot});

    always_comb begin
        case (ph_eff)
            PHASE_ATTACK: begin
                if (sum >= ONE_SUM) begin
                    nxt.level = ONE_Q22;
                    nxt.phase = PHASE_DECAY;
                end else if (sum < 0) begin
                    nxt.level = '0;
                    nxt.phase = PHASE_ATTACK;
                end else begin
                    nxt.level = sum[LEVEL_W-1:0];
                    nxt.phase = PHASE_ATTACK;
                end
            end
            PHASE_DECAY: begin
                if (sum <= 0) begin
                    nxt.level = '0;
                    nxt.phase = PHASE_IDLE;
                end else if (sum > ONE_SUM) begin
                    nxt.level = ONE_Q22;
                    nxt.phase = PHASE_DECAY;
                end else begin
                    nxt.level = sum[LEVEL_W-1:0];
                    nxt.phase = PHASE_DECAY;
                end
            end
            default: begin
                nxt.level = '0;
                nxt.phase = PHASE_IDLE;
            end
        endcase
    end

endmodule

@@ design/attack_decay_envelope.sv @@
// Attack-decay envelope generator top level: handshakes, registers, state.
//
//   channel  dir  handshake         word
//   s_       in   s_valid/s_ready   s_trigger
//   m_       out  m_valid/m_ready   m_level, m_phase
//   cfg_     in   cfg_we            cfg_index, cfg_data
//
// One word per cycle sustained while m_ready stays high. A word is held in the
// input register, then the multiply, add and clamp of ade_step write the state
// register, which doubles as the result register, once that register is free.
// Synchronous active-low reset clears both valid flags, sets phase to idle,
// level to zero and the registers to their defaults. A stalled m_ready holds
// the result; the input register still takes one more word before s_ready drops.
`include "attack_decay_envelope_assert.svh"

module attack_decay_envelope
    import ade_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // sample input
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_trigger,
    // envelope output
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [LEVEL_W-1:0]      m_level,
    output logic [PHASE_CODE_W-1:0] m_phase,
    // register writes
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [COEFF_W-1:0]      cfg_data
);

    ade_cfg_t   cfg_reg;
    logic       in_valid_reg;
    logic       in_trigger_reg;
    logic       out_valid_reg;
    ade_state_t state_reg;
    ade_state_t state_next;
    logic       advance;

    // Move the held word to the result register when that register is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Register file: write only, no wait.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attack_coeff  <= ATTACK_COEFF_RST;
            cfg_reg.decay_coeff   <= DECAY_COEFF_RST;
            cfg_reg.attack_target <= ATTACK_TARGET_RST;
            cfg_reg.decay_target  <= DECAY_TARGET_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ATTACK_COEFF:  cfg_reg.attack_coeff  <= cfg_data;
                CFG_DECAY_COEFF:   cfg_reg.decay_coeff   <= cfg_data;
                CFG_ATTACK_TARGET: cfg_reg.attack_target <= cfg_data[LEVEL_W-1:0];
                CFG_DECAY_TARGET:  cfg_reg.decay_target  <= cfg_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: hold the trigger until it advances.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_trigger_reg <= s_trigger;
        end
    end

    ade_step u_step (
        .cfg     (cfg_reg),
        .cur     (state_reg),
        .trigger (in_trigger_reg),
        .nxt     (state_next)
    );

    // The state doubles as the result register: it changes only on advance,
    // which needs the previous result taken or absent.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            state_reg.phase <= PHASE_IDLE;
            state_reg.level <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_level = state_reg.level;

    always_comb begin
        case (state_reg.phase)
            PHASE_ATTACK: m_phase = PH_CODE_ATTACK;
            PHASE_DECAY:  m_phase = PH_CODE_DECAY;
            default:      m_phase = PH_CODE_IDLE;
        endcase
    end

    `ADE_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid, "result valid after reset")
    `ADE_ASSERT(a_idle_is_zero, state_reg.phase == PHASE_IDLE |-> state_reg.level == '0, "idle level not zero")
    `ADE_ASSERT(a_attack_below_one, state_reg.phase == PHASE_ATTACK |-> state_reg.level < ONE_Q22, "attack held at full scale")
    `ADE_ASSERT(a_held_word_moves, in_valid_reg && !out_valid_reg |=> out_valid_reg, "held word did not advance")

endmodule
